>>> rtl/core/mbrot_pkg.sv
// ----------------------------------------------------------------------------
// mbrot_pkg
// Shared types and constants of the escape-time pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrot_pkg;

	localparam int IMAGE_DIM_DEF = 1024;
	localparam int FRAC_BITS_DEF = 28;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [31:0] REAL_START_RST = 32'hE000_0000;
	localparam logic [30:0] REAL_STEP_RST  = 31'd1464188;
	localparam logic [31:0] IMAG_START_RST = 32'hF000_0000;
	localparam logic [30:0] IMAG_STEP_RST  = 31'd976125;
	localparam logic [15:0] MAX_ITER_RST   = 16'd1000;

	localparam logic [7:0] GREEN_MOD = 8'd205;
	localparam logic [7:0] BLUE_MOD  = 8'd250;

	typedef enum logic [2:0] {
		REG_REAL_START = 3'd0,
		REG_REAL_STEP  = 3'd1,
		REG_IMAG_START = 3'd2,
		REG_IMAG_STEP  = 3'd3,
		REG_MAX_ITER   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [9:0]  out_x;
		logic [9:0]  out_y;
		logic [15:0] escape_count;
		logic [6:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} result_t;

	typedef struct packed {
		logic signed [31:0] real_start;
		logic [30:0]        real_step;
		logic signed [31:0] imag_start;
		logic [30:0]        imag_step;
		logic [15:0]        max_iterations;
	} cfg_t;

	// One mapped point waiting for the iteration engine.
	typedef struct packed {
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
		logic [9:0]         x;
		logic [9:0]         y;
	} job_t;

endpackage

`default_nettype wire

>>> rtl/core/mbrot_front.sv
// ----------------------------------------------------------------------------
// mbrot_front
// Accepts pixel requests and maps them to complex points c = start + idx*step.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrot_front #(
	parameter int IMAGE_DIM = mbrot_pkg::IMAGE_DIM_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  mbrot_pkg::pixel_t   pixel,
	input  mbrot_pkg::cfg_t     cfg,
	output logic                job_push,
	input  wire                 job_full,
	output mbrot_pkg::job_t     job
);
	import mbrot_pkg::*;

	localparam logic [16:0] LIM = 17'(IMAGE_DIM - 1);

	logic        valid_s1;
	logic [40:0] prod_r_s1, prod_i_s1;
	logic [9:0]  x_s1, y_s1;
	logic        advance;
	logic [9:0]  idx_x, idx_y;
	logic signed [42:0] sum_r, sum_i;

	assign advance  = !valid_s1 || !job_full;
	assign full     = !advance;
	assign job_push = valid_s1 && !job_full;

	// Indices beyond the image are clamped for the mapping only.
	always_comb begin
		idx_x = ({7'd0, pixel.pixel_x} > LIM) ? LIM[9:0] : pixel.pixel_x;
		idx_y = ({7'd0, pixel.pixel_y} > LIM) ? LIM[9:0] : pixel.pixel_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			prod_r_s1 <= 41'(idx_x) * 41'(cfg.real_step);
			prod_i_s1 <= 41'(idx_y) * 41'(cfg.imag_step);
			x_s1      <= pixel.pixel_x;
			y_s1      <= pixel.pixel_y;
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		logic signed [31:0] r;
		if (v[42:31] == '0 || v[42:31] == '1) begin
			r = v[31:0];
		end else if (v[42]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	always_comb begin
		sum_r    = 43'(cfg.real_start) + $signed({2'b00, prod_r_s1});
		sum_i    = 43'(cfg.imag_start) + $signed({2'b00, prod_i_s1});
		job.c_re = sat32(sum_r);
		job.c_im = sat32(sum_i);
		job.x    = x_s1;
		job.y    = y_s1;
	end

endmodule

`default_nettype wire

>>> rtl/core/mbrot_queue.sv
// ----------------------------------------------------------------------------
// mbrot_queue
// Short queue of mapped points between the front and the iteration engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrot_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_en,
	output logic             q_full,
	input  mbrot_pkg::job_t  wr_data,
	input  wire              rd_en,
	output logic             q_empty,
	output mbrot_pkg::job_t  rd_data
);
	import mbrot_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_wr, do_rd;

	assign q_full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

>>> rtl/core/mbrot_engine.sv
// ----------------------------------------------------------------------------
// mbrot_engine
// Iterates z = z*z + c for one point at a time and holds the finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrot_engine #(
	parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  mbrot_pkg::job_t     job,
	input  wire                 job_valid,
	output logic                job_pop,
	input  wire [15:0]          limit,
	output logic                empty,
	input  wire                 pop,
	output mbrot_pkg::result_t  result
);
	import mbrot_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD, ST_DONE} state_t;

	localparam logic [64:0] FOUR = 65'd4 << FRAC_BITS;

	state_t             state_q;
	logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
	logic signed [63:0] prr_q, pii_q, pri_q;
	logic [15:0]        count_q;
	logic [7:0]         m205_q, m250_q;
	logic [9:0]         x_q, y_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [63:0]        sqr, sqi;
	logic [64:0]        mag2;
	logic signed [65:0] nr, ni;
	logic               out_free;

	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign out_free = !res_valid_q || pop;
	assign empty    = !res_valid_q;
	assign result   = res_q;

	always_comb begin
		sqr  = 64'(prr_q >>> FRAC_BITS);
		sqi  = 64'(pii_q >>> FRAC_BITS);
		mag2 = {1'b0, sqr} + {1'b0, sqi};
		nr   = $signed({2'b00, sqr}) - $signed({2'b00, sqi}) + 66'(cr_q);
		ni   = 66'(pri_q >>> (FRAC_BITS - 1)) + 66'(ci_q);
	end

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v[65:31] == '0 || v[65:31] == '1) begin
			r = v[31:0];
		end else if (v[65]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			zr_q <= '0; zi_q <= '0; cr_q <= '0; ci_q <= '0;
			prr_q <= '0; pii_q <= '0; pri_q <= '0;
			count_q <= '0; m205_q <= '0; m250_q <= '0;
			x_q <= '0; y_q <= '0;
			res_q <= '0;
		end else begin
			if (pop && res_valid_q && !(state_q == ST_DONE && out_free))
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						cr_q    <= job.c_re;
						ci_q    <= job.c_im;
						x_q     <= job.x;
						y_q     <= job.y;
						zr_q    <= '0;
						zi_q    <= '0;
						count_q <= '0;
						m205_q  <= '0;
						m250_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (count_q >= limit) begin
						state_q <= ST_DONE;
					end else begin
						prr_q   <= zr_q * zr_q;
						pii_q   <= zi_q * zi_q;
						pri_q   <= zr_q * zi_q;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (mag2 >= FOUR) begin
						state_q <= ST_DONE;
					end else begin
						zr_q    <= sat32(nr);
						zi_q    <= sat32(ni);
						count_q <= count_q + 16'd1;
						// Color residues are kept as wrapping counters.
						m205_q  <= (m205_q == GREEN_MOD - 8'd1) ? 8'd0 : m205_q + 8'd1;
						m250_q  <= (m250_q == BLUE_MOD - 8'd1) ? 8'd0 : m250_q + 8'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_q.out_x        <= x_q;
						res_q.out_y        <= y_q;
						res_q.escape_count <= count_q;
						res_q.red          <= count_q[6:0];
						res_q.green        <= m205_q;
						res_q.blue         <= m250_q;
						res_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time engine: maps a pixel to c and counts iterations of z*z + c.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  pixel     push / full          pixel_t   (pixel_x, pixel_y)
//  result    pop / empty          result_t  (indices, count, color)
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Each iteration passes through a multiply state, using the three 32x32
//  multipliers, and an add state for the add, escape compare and saturation;
//  a pixel leaves the loop when it escapes or reaches the limit. The front
//  maps coordinates with registered index-step products and a combinational
//  add, and a four-entry queue lets it run ahead of the engine. Reset clears all control
//  state and loads the register defaults. A stalled result stays in the output
//  register while the engine starts the next point.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel #(
	parameter int IMAGE_DIM = mbrot_pkg::IMAGE_DIM_DEF,
	parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  mbrot_pkg::pixel_t   pixel,
	output logic                empty,
	input  wire                 pop,
	output mbrot_pkg::result_t  result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [2:0]           cfg_index,
	input  wire [31:0]          cfg_data
);
	import mbrot_pkg::*;

	cfg_t cfg_q;
	job_t front_job, queue_job;
	logic job_push, job_full, job_empty, job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_start     <= REAL_START_RST;
			cfg_q.real_step      <= REAL_STEP_RST;
			cfg_q.imag_start     <= IMAG_START_RST;
			cfg_q.imag_step      <= IMAG_STEP_RST;
			cfg_q.max_iterations <= MAX_ITER_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_REAL_START: cfg_q.real_start     <= cfg_data;
				REG_REAL_STEP:  cfg_q.real_step      <= cfg_data[30:0];
				REG_IMAG_START: cfg_q.imag_start     <= cfg_data;
				REG_IMAG_STEP:  cfg_q.imag_step      <= cfg_data[30:0];
				REG_MAX_ITER:   cfg_q.max_iterations <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	mbrot_front #(.IMAGE_DIM(IMAGE_DIM)) u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .pixel(pixel), .cfg(cfg_q),
		.job_push(job_push), .job_full(job_full), .job(front_job)
	);

	mbrot_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_en(job_push), .q_full(job_full), .wr_data(front_job),
		.rd_en(job_pop), .q_empty(job_empty), .rd_data(queue_job)
	);

	mbrot_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.job(queue_job), .job_valid(!job_empty), .job_pop(job_pop),
		.limit(cfg_q.max_iterations),
		.empty(empty), .pop(pop), .result(result)
	);

	a_full_only_when_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> job_full)
		else $error("input stalled while the point queue had room");

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.escape_count <= cfg_q.max_iterations)
		else $error("escape count beyond the iteration limit");

	a_color_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.red == result.escape_count[6:0]) && (result.green < GREEN_MOD)
			&& (result.blue < BLUE_MOD))
		else $error("color residue out of range");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished before it was taken");

endmodule

`default_nettype wire
